FILE: sv/md5_pkg.sv
// md5_pkg: shared types, constants and round helpers for the md5 digest core
// no dependencies; imported by md5_message_digest_core

package md5_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_ADD
    } md5_state_t;

    // what follows the compression in flight
    typedef enum logic [1:0] {
        PH_DATA,
        PH_PADDED,
        PH_FINAL
    } md5_phase_t;

    typedef logic [31:0] word_t;

    localparam word_t IV_A = 32'h67452301;
    localparam word_t IV_B = 32'hefcdab89;
    localparam word_t IV_C = 32'h98badcfe;
    localparam word_t IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_POS   = 6'd63;

    localparam word_t ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotate amount by round group and round within group of four
    function automatic logic [4:0] rot_amount(input logic [1:0] grp, input logic [1:0] sub);
        logic [4:0] s;
        case ({grp, sub})
            4'h0: s = 5'd7;
            4'h1: s = 5'd12;
            4'h2: s = 5'd17;
            4'h3: s = 5'd22;
            4'h4: s = 5'd5;
            4'h5: s = 5'd9;
            4'h6: s = 5'd14;
            4'h7: s = 5'd20;
            4'h8: s = 5'd4;
            4'h9: s = 5'd11;
            4'ha: s = 5'd16;
            4'hb: s = 5'd23;
            4'hc: s = 5'd6;
            4'hd: s = 5'd10;
            4'he: s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic word_t rotl32(input word_t v, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {v, v} << s;
        return dbl[63:32];
    endfunction

    // message word index for a round
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] r4;
        logic [3:0] g;
        r4 = r[3:0];
        case (r[5:4])
            2'd0: g = r4;
            2'd1: g = 4'(r4 + {r4[1:0], 2'b00} + 4'd1);
            2'd2: g = 4'(r4 + {r4[2:0], 1'b0} + 4'd5);
            default: g = 4'({r4[0], 3'b000} - r4);
        endcase
        return g;
    endfunction

    function automatic word_t round_func(input logic [1:0] grp, input word_t b,
                                         input word_t c, input word_t d);
        word_t f;
        case (grp)
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (b & d) | (c & ~d);
            2'd2: f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

endpackage

FILE: sv/md5_message_digest_core.sv
// md5_message_digest_core: byte-serial md5 digest with one shared round unit
// depends on md5_pkg

// Usage
//   input channel (in_valid / in_ready): one transaction per message byte;
//   byte_valid = 0 with end_of_message = 1 closes a message without a byte,
//   byte_valid = 0 with end_of_message = 0 is an idle transaction.
//   output channel (out_valid / out_ready): two transactions per message,
//   digest bytes 0-7 (half_index 0) then bytes 8-15 (half_index 1,
//   last_result 1), first digest byte in bits 7:0.
// Sequence
//   a byte that neither fills a block nor ends the message keeps in_ready
//   high. a byte that fills the 64-byte block starts a compression: rounds
//   through the single round unit and the chaining add, with in_ready low.
//   end of message adds a padding step and one compression, or padding and
//   length steps and two compressions when 56 or more bytes sit in the last
//   block. the first digest half is shown on the cycle after the final add.
// Reset and stall
//   reset loads the initial chaining words and clears block, count and
//   both channels. the digest sits in its own output register, so input
//   bytes of the next message are taken while it waits; only the final
//   chaining add of the next message waits for the output register to empty.

module md5_message_digest_core
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_half,
    output logic        half_index,
    output logic        last_result
);

    md5_state_t  state_reg, state_next;
    md5_phase_t  phase_reg, phase_next;
    logic        eom_reg, eom_next;
    logic [5:0]  round_reg, round_next;
    logic [60:0] count_reg, count_next;
    word_t       chain_reg [4];
    word_t       chain_next [4];
    word_t       work_reg [4];
    word_t       work_next [4];
    word_t       block_reg [16];
    word_t       block_next [16];
    logic [127:0] digest_reg, digest_next;
    logic        out_valid_reg, out_valid_next;
    logic        half_reg, half_next;

    logic        in_fire;
    logic        out_fire;
    logic [5:0]  pos;
    logic [1:0]  grp;
    word_t       f_val;
    word_t       sum;
    word_t       rot;
    logic [63:0] bit_len;
    word_t       added [4];

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign pos      = count_reg[5:0];
    assign grp      = round_reg[5:4];
    assign bit_len  = {count_reg, 3'b000};

    // shared round unit
    assign f_val = round_func(grp, work_reg[1], work_reg[2], work_reg[3]);
    assign sum   = work_reg[0] + f_val + ROUND_K[round_reg] + block_reg[msg_index(round_reg)];
    assign rot   = work_reg[1] + rotl32(sum, rot_amount(grp, round_reg[1:0]));

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            added[k] = chain_reg[k] + work_reg[k];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (byte_valid && pos == LAST_POS)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:   state_next = ST_ROUND;
            ST_LEN:   state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                case (phase_reg)
                    PH_FINAL:
                    begin
                        if (!out_valid_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    PH_PADDED: state_next = ST_LEN;
                    default:   state_next = eom_reg ? ST_PAD : ST_IDLE;
                endcase
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        phase_next     = phase_reg;
        eom_next       = eom_reg;
        round_next     = round_reg;
        count_next     = count_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        block_next     = block_reg;
        digest_next    = digest_reg;
        out_valid_next = out_valid_reg;
        half_next      = half_reg;
        in_ready       = 1'b0;

        if (out_fire)
        begin
            if (half_reg)
            begin
                out_valid_next = 1'b0;
                half_next      = 1'b0;
            end
            else
            begin
                half_next = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    eom_next   = end_of_message;
                    phase_next = PH_DATA;
                    round_next = '0;
                    work_next  = chain_reg;
                    if (byte_valid)
                    begin
                        block_next[pos[5:2]] = block_reg[pos[5:2]]
                            | (word_t'(data_byte) << {pos[1:0], 3'b000});
                        count_next = count_reg + 61'd1;
                    end
                end
            end
            ST_PAD:
            begin
                block_next[pos[5:2]] = block_reg[pos[5:2]]
                    | (word_t'(PAD_BYTE) << {pos[1:0], 3'b000});
                round_next = '0;
                work_next  = chain_reg;
                if (pos >= LEN_POS)
                begin
                    phase_next = PH_PADDED;
                end
                else
                begin
                    phase_next     = PH_FINAL;
                    block_next[14] = bit_len[31:0];
                    block_next[15] = bit_len[63:32];
                end
            end
            ST_LEN:
            begin
                phase_next     = PH_FINAL;
                round_next     = '0;
                work_next      = chain_reg;
                block_next[14] = bit_len[31:0];
                block_next[15] = bit_len[63:32];
            end
            ST_ROUND:
            begin
                round_next   = round_reg + 6'd1;
                work_next[0] = work_reg[3];
                work_next[1] = rot;
                work_next[2] = work_reg[1];
                work_next[3] = work_reg[2];
            end
            ST_ADD:
            begin
                if (phase_reg != PH_FINAL)
                begin
                    chain_next = added;
                    for (int k = 0; k < 16; k++)
                    begin
                        block_next[k] = '0;
                    end
                end
                else if (!out_valid_reg)
                begin
                    // digest to output register, then back to the initial state
                    digest_next    = {added[3], added[2], added[1], added[0]};
                    out_valid_next = 1'b1;
                    half_next      = 1'b0;
                    chain_next[0]  = IV_A;
                    chain_next[1]  = IV_B;
                    chain_next[2]  = IV_C;
                    chain_next[3]  = IV_D;
                    count_next     = '0;
                    eom_next       = 1'b0;
                    for (int k = 0; k < 16; k++)
                    begin
                        block_next[k] = '0;
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_DATA;
            eom_reg       <= 1'b0;
            round_reg     <= '0;
            count_reg     <= '0;
            chain_reg[0]  <= IV_A;
            chain_reg[1]  <= IV_B;
            chain_reg[2]  <= IV_C;
            chain_reg[3]  <= IV_D;
            for (int k = 0; k < 16; k++)
            begin
                block_reg[k] <= '0;
            end
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            eom_reg       <= eom_next;
            round_reg     <= round_next;
            count_reg     <= count_next;
            chain_reg     <= chain_next;
            block_reg     <= block_next;
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        digest_reg <= digest_next;
    end

    assign out_valid   = out_valid_reg;
    assign half_index  = half_reg;
    assign last_result = half_reg;
    assign digest_half = half_reg ? digest_reg[127:64] : digest_reg[63:0];

endmodule

FILE: sv/md5_checker.sv
// md5_checker: port-level assertions for md5_message_digest_core, bound to the top
// depends on md5_message_digest_core ports only

module md5_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        end_of_message,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] digest_half,
    input logic        half_index,
    input logic        last_result
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_half) && $stable(half_index))
        else $error("result changed while stalled");

    // last flag marks the second half only
    a_last_half: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_result == half_index))
        else $error("last_result does not match half_index");

    // second half follows the first without a gap
    a_second_half: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !half_index |=> out_valid && half_index)
        else $error("second digest half missing");

    // end of message starts padding, or a compression when its byte fills the block, so input stalls next cycle
    a_eom_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_message |=> !in_ready)
        else $error("input accepted during end-of-message padding");

endmodule

bind md5_message_digest_core md5_checker u_md5_checker (.*);

FILE: sim/tb_md5_message_digest_core.sv
// tb_md5_message_digest_core: self-checking bench for the byte-serial md5 digest core
// depends on md5_message_digest_core (and md5_pkg through it); digests are predicted in place
// directed message table first, then random messages, with random idling on both channels

`timescale 1ns / 1ps

module tb_md5_message_digest_core;

    // run shape
    localparam int RANDOM_ITEMS  = 536;     // message transactions after the table
    localparam int HOLD_AT       = 6;       // digest halves seen before the long hold-off
    localparam int HOLD_CYCLES   = 800;
    localparam int DRAIN_CYCLES  = 300;     // two compressions plus margin
    localparam int CYCLE_LIMIT   = 500000;

    // md5 initial chaining words
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    // additive constant per round
    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // left-rotate amount by round group and position within a group of four
    localparam int ROT_BY [4][4] = '{
        '{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}
    };

    // lengths that sit on the padding boundaries, sent as the first random messages
    localparam int BOUNDARY_LEN [5] = '{55, 56, 63, 64, 0};

    typedef struct packed {
        logic [63:0] bytes;
        logic        index;
        logic        last;
    } digest_half_t;

    // one row of the directed table; known digests are typed in where the message
    // is a textbook one, every other row falls back to the predictor
    typedef struct packed {
        logic [7:0]  data;
        logic        valid_byte;
        logic        ends_message;
        logic        known;
        logic [63:0] known_lo;
        logic [63:0] known_hi;
    } stim_row_t;

    localparam int N_ROWS = 14;
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        // empty message right after reset
        '{8'h00, 1'b0, 1'b1, 1'b1, 64'h04b2008fd98c1dd4, 64'h7e42f8ec980980e9},
        // idle transaction with every data bit set, must be ignored
        '{8'hff, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        // "a" closed on its own byte
        '{8'h61, 1'b1, 1'b1, 1'b1, 64'ha8b6f1c0b975c10c, 64'h61267769e299c331},
        // data extremes, an idle in the middle, closed by a byte-less end marker
        '{8'h00, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0},
        // one-byte messages at both data extremes
        '{8'hff, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
        // empty message again: chaining words must be back at their start values
        '{8'hff, 1'b0, 1'b1, 1'b1, 64'h04b2008fd98c1dd4, 64'h7e42f8ec980980e9},
        // "abc"
        '{8'h61, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, 64'hb04fd23c98500190, 64'h727fe1287d3f96d6}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        end_of_message;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] digest_half;
    logic        half_index;
    logic        last_result;

    // digest predictor state
    logic [31:0] hash_chain [4];
    logic [31:0] hash_block [16];
    logic [60:0] msg_len_bytes;

    digest_half_t pending_halves [$];

    int mismatch_count = 0;
    int halves_seen    = 0;
    int cycle_count    = 0;
    int send_burst     = 0;
    int recv_burst     = 0;

    md5_message_digest_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_half    (digest_half),
        .half_index     (half_index),
        .last_result    (last_result)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop in case the core hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // back to the state of a fresh message
    function automatic void clear_digest_state();
        hash_chain[0] = INIT_A;
        hash_chain[1] = INIT_B;
        hash_chain[2] = INIT_C;
        hash_chain[3] = INIT_D;
        foreach (hash_block[i])
            hash_block[i] = '0;
        msg_len_bytes = '0;
    endfunction

    // little-endian byte lane inside the 16-word block
    function automatic void pack_byte(input logic [5:0] pos, input logic [7:0] b);
        hash_block[pos[5:2]] |= {24'b0, b} << (8 * pos[1:0]);
    endfunction

    // 64 rounds on the collected block, then fold into the chaining words
    function automatic void compress_block();
        logic [31:0] a, b, c, d, f, t;
        int grp, w, s;
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        for (int r = 0; r < 64; r++)
        begin
            grp = r / 16;
            case (grp)
                0:
                begin
                    f = (b & c) | (~b & d);
                    w = r % 16;
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    w = (5 * r + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    w = (3 * r + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    w = (7 * r) % 16;
                end
            endcase
            t = a + f + SINE_K[r] + hash_block[w];
            s = ROT_BY[grp][r % 4];
            a = d;
            d = c;
            c = b;
            b = b + ((t << s) | (t >> (32 - s)));
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
        foreach (hash_block[i])
            hash_block[i] = '0;
    endfunction

    // one accepted input transaction; done is set when a digest comes out of it
    function automatic void absorb_item(input logic [7:0] b, input logic bv, input logic eom,
                                        output logic done, output logic [63:0] lo,
                                        output logic [63:0] hi);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        done = 1'b0;
        lo = '0;
        hi = '0;
        if (bv)
        begin
            pos = msg_len_bytes[5:0];
            pack_byte(pos, b);
            msg_len_bytes = msg_len_bytes + 61'd1;
            if (pos == 6'd63)
                compress_block();
        end
        if (eom)
        begin
            // pad byte, spill block when the length field no longer fits
            pos = msg_len_bytes[5:0];
            pack_byte(pos, PAD_MARK);
            if (pos >= 6'd56)
                compress_block();
            bit_len = {msg_len_bytes, 3'b000};
            hash_block[14] = bit_len[31:0];
            hash_block[15] = bit_len[63:32];
            compress_block();
            done = 1'b1;
            lo = {hash_chain[1], hash_chain[0]};
            hi = {hash_chain[3], hash_chain[2]};
            clear_digest_state();
        end
    endfunction

    // per-transaction wait: mostly a random idle gap, now and then a burst with no gaps
    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // drive one input transaction; entered and left at a falling edge
    task automatic offer_item(input logic [7:0] b, input logic bv, input logic eom,
                              input logic known, input logic [63:0] known_lo,
                              input logic [63:0] known_hi);
        int          gap;
        logic        done;
        logic [63:0] lo, hi;
        gap = draw_gap(send_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        byte_valid     <= bv;
        end_of_message <= eom;
        do
            @(posedge clk);
        while (!in_ready);
        // transaction taken at this edge
        absorb_item(b, bv, eom, done, lo, hi);
        if (done)
        begin
            if (known)
            begin
                lo = known_lo;
                hi = known_hi;
            end
            pending_halves.push_back('{bytes: lo, index: 1'b0, last: 1'b0});
            pending_halves.push_back('{bytes: hi, index: 1'b1, last: 1'b1});
        end
        @(negedge clk);
    endtask

    // output side: random ready gaps, one long hold-off, check against the oldest expectation
    initial
    begin : digest_sink
        int           gap;
        logic         held;
        digest_half_t want;
        out_ready = 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            // hold off long enough that the next digest backs up into the input
            if (!held && halves_seen >= HOLD_AT)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = draw_gap(recv_burst);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            halves_seen++;
            if (pending_halves.size() == 0)
            begin
                $error("unexpected digest transaction: digest_half %h", digest_half);
                mismatch_count++;
            end
            else
            begin
                want = pending_halves.pop_front();
                if (digest_half !== want.bytes)
                begin
                    $error("digest_half expected %h actual %h", want.bytes, digest_half);
                    mismatch_count++;
                end
                if (half_index !== want.index)
                begin
                    $error("half_index expected %b actual %b", want.index, half_index);
                    mismatch_count++;
                end
                if (last_result !== want.last)
                begin
                    $error("last_result expected %b actual %b", want.last, last_result);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int   len, sel, sent, messages;
        logic close_on_byte;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = '0;
        byte_valid     = 1'b0;
        end_of_message = 1'b0;
        clear_digest_state();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int row = 0; row < N_ROWS; row++)
            offer_item(DIRECTED_ROWS[row].data, DIRECTED_ROWS[row].valid_byte,
                       DIRECTED_ROWS[row].ends_message, DIRECTED_ROWS[row].known,
                       DIRECTED_ROWS[row].known_lo, DIRECTED_ROWS[row].known_hi);

        // random messages: mostly short, some around the padding spill, a few multi-block
        sent = 0;
        messages = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (messages < 5)
                len = BOUNDARY_LEN[messages];
            else
            begin
                sel = $urandom_range(0, 7);
                if (sel < 4)
                    len = $urandom_range(0, 12);
                else if (sel < 6)
                    len = $urandom_range(52, 68);
                else if (sel == 6)
                    len = $urandom_range(110, 135);
                else
                    len = $urandom_range(0, 64);
            end
            close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            for (int k = 0; k < len; k++)
            begin
                // stray idle transaction as noise
                if ($urandom_range(0, 11) == 0)
                begin
                    offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0, '0);
                    sent++;
                end
                offer_item(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (k == len - 1),
                           1'b0, '0, '0);
                sent++;
            end
            if (!close_on_byte)
            begin
                offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0, '0);
                sent++;
            end
            messages++;
        end
        in_valid <= 1'b0;

        // wait out the digests still in flight, then watch for strays
        while (pending_halves.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_halves.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
